// ===== design/quoted_word_splitter_defines.svh =====
// Assertion macros shared by the quoted word splitter RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef QUOTED_WORD_SPLITTER_DEFINES_SVH
`define QUOTED_WORD_SPLITTER_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define QWS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// An implication checked in the same cycle.
`define QWS_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== design/qws_pkg.sv =====
// Package for the quoted word splitter: widths, character codes, result kinds,
// mode encoding and the result group type. Depends on nothing.
package qws_pkg;

  localparam int ARG_SLOTS_DEF = 64;
  localparam int BYTE_W        = 8;
  localparam int IDX_W         = 6;
  localparam int MAX_RES       = 3;

  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_BSL   = 8'h5c;
  localparam logic [BYTE_W-1:0] CH_SQ    = 8'h27;
  localparam logic [BYTE_W-1:0] CH_DQ    = 8'h22;

  typedef enum logic [1:0] {
    K_BYTE  = 2'd0,
    K_WEND  = 2'd1,
    K_LINE  = 2'd2,
    K_ERROR = 2'd3
  } kind_t;

  // Lexer modes, one-hot.
  typedef enum logic [6:0] {
    M_BETWEEN = 7'b0000001,
    M_WORD    = 7'b0000010,
    M_ESC     = 7'b0000100,
    M_SQ      = 7'b0001000,
    M_DQ      = 7'b0010000,
    M_DQESC   = 7'b0100000,
    M_DISCARD = 7'b1000000
  } mode_t;

  typedef struct packed {
    kind_t              kind;
    logic [BYTE_W-1:0]  out_byte;
    logic [IDX_W-1:0]   word_index;
    logic [IDX_W-1:0]   word_total;
  } res_t;

  // All results caused by one input word, in order from res[0].
  typedef struct packed {
    logic [1:0]           n;
    res_t [MAX_RES-1:0]   res;
  } grp_t;

endpackage

// ===== design/qws_lexer.sv =====
// Mode machine of the quoted word splitter: holds mode and word count and
// turns one input word into a group of up to three results. Uses qws_pkg.
module qws_lexer
  import qws_pkg::*;
#(
  parameter int ARG_SLOTS = ARG_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [BYTE_W-1:0] ch,
  input  logic              accept,
  output grp_t              grp
);

  typedef struct packed {
    mode_t             mode;
    logic [IDX_W-1:0]  cnt;
    grp_t              grp;
  } step_t;

  localparam logic [IDX_W-1:0] CNT_LIMIT = IDX_W'(ARG_SLOTS - 1);

  mode_t            mode_r, mode_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             blank;
  logic [IDX_W-1:0] idx;
  step_t            ws;

  function automatic res_t mk_res(kind_t k, logic [BYTE_W-1:0] b,
                                  logic [IDX_W-1:0] i, logic [IDX_W-1:0] t);
    res_t r;
    r.kind       = k;
    r.out_byte   = b;
    r.word_index = i;
    r.word_total = t;
    return r;
  endfunction

  // Handling of a byte inside an unquoted part of a word, with cnt words
  // started so far in the line.
  function automatic step_t word_step(logic [BYTE_W-1:0] c, logic [IDX_W-1:0] cnt);
    step_t            s;
    logic [IDX_W-1:0] wi;
    s    = '0;
    wi   = cnt - IDX_W'(1);
    s.mode = M_WORD;
    s.cnt  = cnt;
    if (c == CH_NUL) begin
      s.grp.n      = 2'd2;
      s.grp.res[0] = mk_res(K_WEND, '0, wi, '0);
      s.grp.res[1] = mk_res(K_LINE, '0, '0, cnt);
      s.mode       = M_BETWEEN;
      s.cnt        = '0;
    end else if (c == CH_SPACE || c == CH_TAB) begin
      s.grp.n      = 2'd1;
      s.grp.res[0] = mk_res(K_WEND, '0, wi, '0);
      s.mode       = M_BETWEEN;
    end else if (c == CH_BSL) begin
      s.mode = M_ESC;
    end else if (c == CH_SQ) begin
      s.mode = M_SQ;
    end else if (c == CH_DQ) begin
      s.mode = M_DQ;
    end else begin
      s.grp.n      = 2'd1;
      s.grp.res[0] = mk_res(K_BYTE, c, wi, '0);
    end
    return s;
  endfunction

  assign blank = (ch == CH_SPACE) || (ch == CH_TAB);
  assign idx   = cnt_r - IDX_W'(1);

  // Next mode, word count and result group for the byte on the input.
  always_comb begin
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    grp      = '0;
    ws       = '0;
    unique case (mode_r)
      M_BETWEEN: begin
        if (ch == CH_NUL) begin
          grp.n      = 2'd1;
          grp.res[0] = mk_res(K_LINE, '0, '0, cnt_r);
          cnt_nxt    = '0;
        end else if (!blank) begin
          if (cnt_r >= CNT_LIMIT) begin
            grp.n      = 2'd1;
            grp.res[0] = mk_res(K_ERROR, '0, '0, '0);
            mode_nxt   = M_DISCARD;
          end else begin
            ws       = word_step(ch, cnt_r + IDX_W'(1));
            mode_nxt = ws.mode;
            cnt_nxt  = ws.cnt;
            grp      = ws.grp;
          end
        end
      end
      M_WORD: begin
        ws       = word_step(ch, cnt_r);
        mode_nxt = ws.mode;
        cnt_nxt  = ws.cnt;
        grp      = ws.grp;
      end
      M_ESC: begin
        if (ch == CH_NUL) begin
          grp.n      = 2'd3;
          grp.res[0] = mk_res(K_BYTE, CH_BSL, idx, '0);
          grp.res[1] = mk_res(K_WEND, '0, idx, '0);
          grp.res[2] = mk_res(K_LINE, '0, '0, cnt_r);
          mode_nxt   = M_BETWEEN;
          cnt_nxt    = '0;
        end else begin
          grp.n      = 2'd1;
          grp.res[0] = mk_res(K_BYTE, ch, idx, '0);
          mode_nxt   = M_WORD;
        end
      end
      M_SQ: begin
        if (ch == CH_NUL) begin
          grp.n      = 2'd1;
          grp.res[0] = mk_res(K_ERROR, '0, '0, '0);
          mode_nxt   = M_BETWEEN;
          cnt_nxt    = '0;
        end else if (ch == CH_SQ) begin
          mode_nxt = M_WORD;
        end else begin
          grp.n      = 2'd1;
          grp.res[0] = mk_res(K_BYTE, ch, idx, '0);
        end
      end
      M_DQ: begin
        if (ch == CH_NUL) begin
          grp.n      = 2'd1;
          grp.res[0] = mk_res(K_ERROR, '0, '0, '0);
          mode_nxt   = M_BETWEEN;
          cnt_nxt    = '0;
        end else if (ch == CH_DQ) begin
          mode_nxt = M_WORD;
        end else if (ch == CH_BSL) begin
          mode_nxt = M_DQESC;
        end else begin
          grp.n      = 2'd1;
          grp.res[0] = mk_res(K_BYTE, ch, idx, '0);
        end
      end
      M_DQESC: begin
        if (ch == CH_NUL) begin
          grp.n      = 2'd1;
          grp.res[0] = mk_res(K_ERROR, '0, '0, '0);
          mode_nxt   = M_BETWEEN;
          cnt_nxt    = '0;
        end else begin
          grp.n      = 2'd1;
          grp.res[0] = mk_res(K_BYTE, ch, idx, '0);
          mode_nxt   = M_DQ;
        end
      end
      M_DISCARD: begin
        if (ch == CH_NUL) begin
          mode_nxt = M_BETWEEN;
          cnt_nxt  = '0;
        end
      end
      default: begin
        mode_nxt = M_BETWEEN;
        cnt_nxt  = '0;
      end
    endcase
  end

  // Mode and word count advance only when a word is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_BETWEEN;
      cnt_r  <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ===== design/quoted_word_splitter.sv =====
// Quoted word splitter: takes a command line one byte per word and returns word bytes,
// word ends and a line end or error, one result per output word. A byte is taken every
// cycle while the two-group result buffer has room; a byte that causes several results
// holds the output until each of them has been taken, so the sustained input rate is one
// byte per cycle when each byte yields at most one result and the output is not stalled,
// set by the single output port draining the buffer. The results of an accepted byte are
// registered in the group buffer before they are shown. Uses qws_pkg and qws_lexer.
module quoted_word_splitter
  import qws_pkg::*;
#(
  parameter int ARG_SLOTS = ARG_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_ch,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_kind,
  output logic [BYTE_W-1:0] out_byte,
  output logic [IDX_W-1:0]  out_word_index,
  output logic [IDX_W-1:0]  out_word_total,
  output logic              out_last
);

`include "quoted_word_splitter_defines.svh"

  grp_t       grp;
  logic       in_acc;
  logic       push;
  logic       pop_grp;
  logic       out_acc;
  logic       wr_at;
  grp_t       slot_r [2];
  grp_t       slot_nxt [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] pos_r, pos_nxt;
  res_t       head;

  qws_lexer #(
    .ARG_SLOTS (ARG_SLOTS)
  ) u_lexer (
    .clk    (clk),
    .rst_n  (rst_n),
    .ch     (in_ch),
    .accept (in_acc),
    .grp    (grp)
  );

  // Input side: room is judged from the registered fill only.
  assign in_ready = (cnt_r != 2'd2);
  assign in_acc   = in_valid && in_ready;
  assign push     = in_acc && (grp.n != 2'd0);

  // Output side: the head group is shown one result at a time.
  assign head           = slot_r[0].res[pos_r];
  assign out_valid      = (cnt_r != 2'd0);
  assign out_kind       = head.kind;
  assign out_byte       = head.out_byte;
  assign out_word_index = head.word_index;
  assign out_word_total = head.word_total;
  assign out_last       = (pos_r == (slot_r[0].n - 2'd1));
  assign out_acc        = out_valid && out_ready;
  assign pop_grp        = out_acc && out_last;

  // Group buffer update: shift on pop, then write behind the survivors.
  always_comb begin
    slot_nxt[0] = slot_r[0];
    slot_nxt[1] = slot_r[1];
    wr_at       = 1'b0;
    if (pop_grp) begin
      slot_nxt[0] = slot_r[1];
    end
    wr_at = cnt_r[0] && !pop_grp;
    if (push) begin
      slot_nxt[wr_at] = grp;
    end
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop_grp};
    pos_nxt = pos_r;
    if (out_acc) begin
      pos_nxt = out_last ? 2'd0 : pos_r + 2'd1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      pos_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      pos_r <= pos_nxt;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    slot_r[0] <= slot_nxt[0];
    slot_r[1] <= slot_nxt[1];
  end

  `QWS_ASSERT_ALWAYS(a_fill_range, cnt_r != 2'd3, "group buffer fill out of range")
  `QWS_ASSERT_IMPLY(a_head_nonempty, out_valid, slot_r[0].n != 2'd0, "empty group buffered")
  `QWS_ASSERT_IMPLY(a_pos_in_group, out_valid, pos_r < slot_r[0].n, "result position past group")
  `QWS_ASSERT_IMPLY(a_line_is_last, out_valid && (out_kind == K_LINE || out_kind == K_ERROR),
                    out_last, "line result not last of its byte")

endmodule

// ===== tb/word_split_checker.sv =====
// Checker for the quoted word splitter: watches both channels, predicts every
// result from its own model of the lexer and compares them in order.
// Depends on qws_pkg for widths, character codes, result kinds and lexer modes.
module word_split_checker
  import qws_pkg::*;
#(
  parameter int ARG_SLOTS = ARG_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [BYTE_W-1:0] in_ch,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [1:0]        out_kind,
  input  logic [BYTE_W-1:0] out_byte,
  input  logic [IDX_W-1:0]  out_word_index,
  input  logic [IDX_W-1:0]  out_word_total,
  input  logic              out_last,
  output int                fail_count,
  output int                pending,
  output int                results_seen,
  output int                lines_ok,
  output int                lines_err
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PRINTS = 40;

  // One predicted result word.
  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] chr;
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  total;
    logic              last;
  } token_t;

  token_t           token_q[$];
  token_t           step_q[$];
  mode_t            lex_mode;
  logic [IDX_W-1:0] args_open;
  int               prints;

  // Prints one line for a mismatch, up to a limit, and always counts it.
  task automatic report_mismatch(input string what, input logic [BYTE_W-1:0] got,
                                 input logic [BYTE_W-1:0] want);
    fail_count++;
    if (prints < MAX_PRINTS) begin
      $display("[%0t] mismatch on %s: got %h, expected %h (result %0d)",
               $time, what, got, want, results_seen);
    end
    prints++;
  endtask

  function automatic void push_token(kind_t k, logic [BYTE_W-1:0] b,
                                     logic [IDX_W-1:0] idx, logic [IDX_W-1:0] tot);
    token_t t;
    t.kind  = k;
    t.chr   = b;
    t.idx   = idx;
    t.total = tot;
    t.last  = 1'b0;
    step_q.push_back(t);
  endfunction

  function automatic logic [IDX_W-1:0] cur_arg();
    return args_open - 1'b1;
  endfunction

  function automatic logic is_blank(logic [BYTE_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic void clear_line();
    lex_mode  = M_BETWEEN;
    args_open = '0;
  endfunction

  function automatic void end_line_ok();
    push_token(K_LINE, '0, '0, args_open);
    lines_ok++;
    clear_line();
  endfunction

  function automatic void end_line_err();
    push_token(K_ERROR, '0, '0, '0);
    lines_err++;
    clear_line();
  endfunction

  // A byte seen while inside an unquoted part of an argument.
  function automatic void arg_byte(logic [BYTE_W-1:0] c);
    if (c == CH_NUL) begin
      push_token(K_WEND, '0, cur_arg(), '0);
      end_line_ok();
    end else if (is_blank(c)) begin
      push_token(K_WEND, '0, cur_arg(), '0);
      lex_mode = M_BETWEEN;
    end else if (c == CH_BSL) begin
      lex_mode = M_ESC;
    end else if (c == CH_SQ) begin
      lex_mode = M_SQ;
    end else if (c == CH_DQ) begin
      lex_mode = M_DQ;
    end else begin
      push_token(K_BYTE, c, cur_arg(), '0);
    end
  endfunction

  // Predicts the results of one accepted input word and queues them.
  function automatic void split_byte(logic [BYTE_W-1:0] c);
    token_t t;
    step_q.delete();
    case (lex_mode)
      M_BETWEEN: begin
        if (c == CH_NUL) begin
          end_line_ok();
        end else if (!is_blank(c)) begin
          if (int'(args_open) >= ARG_SLOTS - 1) begin
            // Too many arguments: flag the line and drop the rest of it.
            push_token(K_ERROR, '0, '0, '0);
            lines_err++;
            lex_mode = M_DISCARD;
          end else begin
            args_open = args_open + 1'b1;
            lex_mode  = M_WORD;
            arg_byte(c);
          end
        end
      end
      M_WORD: arg_byte(c);
      M_ESC: begin
        if (c == CH_NUL) begin
          // A backslash that ends the line stays a literal byte.
          push_token(K_BYTE, CH_BSL, cur_arg(), '0);
          push_token(K_WEND, '0, cur_arg(), '0);
          end_line_ok();
        end else begin
          push_token(K_BYTE, c, cur_arg(), '0);
          lex_mode = M_WORD;
        end
      end
      M_SQ: begin
        if (c == CH_NUL) end_line_err();
        else if (c == CH_SQ) lex_mode = M_WORD;
        else push_token(K_BYTE, c, cur_arg(), '0);
      end
      M_DQ: begin
        if (c == CH_NUL) end_line_err();
        else if (c == CH_DQ) lex_mode = M_WORD;
        else if (c == CH_BSL) lex_mode = M_DQESC;
        else push_token(K_BYTE, c, cur_arg(), '0);
      end
      M_DQESC: begin
        if (c == CH_NUL) begin
          end_line_err();
        end else begin
          push_token(K_BYTE, c, cur_arg(), '0);
          lex_mode = M_DQ;
        end
      end
      default: begin
        if (c == CH_NUL) clear_line();
      end
    endcase
    for (int i = 0; i < step_q.size(); i++) begin
      t      = step_q[i];
      t.last = (i == step_q.size() - 1);
      token_q.push_back(t);
    end
  endfunction

  // Compares one accepted result word with the oldest prediction.
  task automatic check_result();
    token_t want;
    if (token_q.size() == 0) begin
      report_mismatch("result with nothing expected, kind", BYTE_W'(out_kind), '0);
    end else begin
      want = token_q.pop_front();
      if (out_kind !== want.kind)
        report_mismatch("kind", BYTE_W'(out_kind), BYTE_W'(want.kind));
      if (out_byte !== want.chr)
        report_mismatch("byte", out_byte, want.chr);
      if (out_word_index !== want.idx)
        report_mismatch("word index", BYTE_W'(out_word_index), BYTE_W'(want.idx));
      if (out_word_total !== want.total)
        report_mismatch("word total", BYTE_W'(out_word_total), BYTE_W'(want.total));
      if (out_last !== want.last)
        report_mismatch("last flag", BYTE_W'(out_last), BYTE_W'(want.last));
    end
    results_seen++;
  endtask

  // Results are checked before the new input word is predicted, as the
  // block answers no earlier than the cycle after it takes a byte.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_line();
      token_q.delete();
      fail_count   = 0;
      results_seen = 0;
      lines_ok     = 0;
      lines_err    = 0;
      prints       = 0;
    end else begin
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) split_byte(in_ch);
    end
    pending = token_q.size();
  end

endmodule

// ===== tb/tb_quoted_word_splitter.sv =====
// Testbench top for the quoted word splitter: clock, reset, command-line
// stimulus with idling on both sides, and the verdict.
// Depends on qws_pkg, quoted_word_splitter and word_split_checker.
module tb_quoted_word_splitter;
  timeunit 1ns;
  timeprecision 1ps;
  import qws_pkg::*;

  localparam int HALF_PERIOD    = 10;
  localparam int RESET_CYCLES   = 9;
  localparam int ARG_SLOTS      = ARG_SLOTS_DEF;
  localparam int RANDOM_BYTES   = 430;
  localparam int RX_HOLD_CYCLES = 120;
  localparam int HOLD_BYTES     = 24;
  localparam int DRAIN_CYCLES   = 16;
  localparam int CYCLE_LIMIT    = 100000;

  typedef logic [BYTE_W-1:0] chr_t;

  // How a random line ends: cleanly, inside a quote, on a backslash, or as noise.
  typedef enum int {FL_CLEAN, FL_OPEN_SQ, FL_OPEN_DQ, FL_TAIL_BSL, FL_NOISE} flavour_t;

  // Directed lines: an empty line; extreme bytes, empty quoted arguments and
  // a final backslash; an escape left open inside double quotes; an escaped
  // blank followed by an unterminated single quote.
  localparam chr_t DIRECTED [0:22] = '{
    CH_NUL,
    8'hff, CH_SPACE, CH_SQ, CH_SQ, CH_TAB, CH_DQ, CH_DQ, CH_SPACE, 8'h01, CH_BSL, CH_NUL,
    CH_DQ, 8'h61, CH_BSL, CH_DQ, CH_BSL, CH_NUL,
    CH_BSL, CH_SPACE, CH_SQ, CH_BSL, CH_NUL
  };

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [BYTE_W-1:0] in_ch;
  logic              out_valid;
  logic              out_ready;
  logic [1:0]        out_kind;
  logic [BYTE_W-1:0] out_byte;
  logic [IDX_W-1:0]  out_word_index;
  logic [IDX_W-1:0]  out_word_total;
  logic              out_last;

  int   fail_count;
  int   pending;
  int   results_seen;
  int   lines_ok;
  int   lines_err;

  int   tx_idle_pct;
  int   rx_idle_pct = 45;
  logic hold_req = 1'b0;
  int   bytes_sent;
  int   lines_sent;
  int   cycle_count;
  chr_t line_q[$];

  quoted_word_splitter #(.ARG_SLOTS(ARG_SLOTS)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_ch          (in_ch),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_byte       (out_byte),
    .out_word_index (out_word_index),
    .out_word_total (out_word_total),
    .out_last       (out_last)
  );

  word_split_checker #(.ARG_SLOTS(ARG_SLOTS)) checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_ch          (in_ch),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_byte       (out_byte),
    .out_word_index (out_word_index),
    .out_word_total (out_word_total),
    .out_last       (out_last),
    .fail_count     (fail_count),
    .pending        (pending),
    .results_seen   (results_seen),
    .lines_ok       (lines_ok),
    .lines_err      (lines_err)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Watchdog: ends the run if it has not finished within the limit.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d results outstanding",
             cycle_count, pending);
    $display("TEST FAILED");
    $finish;
  end

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin : result_sink
    int   hold_left;
    logic hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = RX_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= rst_n && ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Offers one input word, with random idle cycles before it, and returns
  // at the falling edge after it has been taken.
  task automatic send_byte(input chr_t c);
    while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_ch    <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  function automatic chr_t plain_chr();
    chr_t c;
    if ($urandom_range(3) != 0) begin
      c = chr_t'($urandom_range(8'h7a, 8'h61));
    end else begin
      c = chr_t'($urandom_range(255, 1));
      while (c == CH_SPACE || c == CH_TAB || c == CH_BSL || c == CH_SQ || c == CH_DQ)
        c = chr_t'($urandom_range(255, 1));
    end
    return c;
  endfunction

  // Any non-zero byte other than the two given.
  function automatic chr_t any_but(chr_t a, chr_t b);
    chr_t c;
    c = chr_t'($urandom_range(255, 1));
    while (c == a || c == b) c = chr_t'($urandom_range(255, 1));
    return c;
  endfunction

  function automatic void add_blanks();
    int n;
    n = $urandom_range(3, 1);
    repeat (n) line_q.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
  endfunction

  // One part of an argument: plain text, an escape, or a quoted group.
  function automatic void add_piece();
    int sel;
    int n;
    sel = $urandom_range(9);
    n   = $urandom_range(4, 0);
    if (sel <= 3) begin
      repeat (n + 1) line_q.push_back(plain_chr());
    end else if (sel == 4) begin
      line_q.push_back(CH_BSL);
      line_q.push_back(chr_t'($urandom_range(255, 1)));
    end else if (sel <= 6) begin
      line_q.push_back(CH_SQ);
      repeat (n) line_q.push_back(any_but(CH_SQ, CH_SQ));
      line_q.push_back(CH_SQ);
    end else if (sel <= 8) begin
      line_q.push_back(CH_DQ);
      repeat (n) begin
        if ($urandom_range(4) == 0) begin
          line_q.push_back(CH_BSL);
          line_q.push_back(chr_t'($urandom_range(255, 1)));
        end else begin
          line_q.push_back(any_but(CH_DQ, CH_BSL));
        end
      end
      line_q.push_back(CH_DQ);
    end else begin
      line_q.push_back(plain_chr());
    end
  endfunction

  // Builds one command line ending in byte 0. Short arguments with a single
  // blank between them keep the lines that reach the argument limit cheap.
  function automatic void build_line(int n_args, flavour_t flavour, logic short_args);
    int n;
    line_q.delete();
    if ($urandom_range(3) == 0) add_blanks();
    for (int i = 0; i < n_args; i++) begin
      if (short_args) begin
        if (i > 0) line_q.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
        line_q.push_back(plain_chr());
      end else begin
        if (i > 0) add_blanks();
        n = $urandom_range(3, 1);
        repeat (n) add_piece();
      end
    end
    n = $urandom_range(3, 0);
    case (flavour)
      FL_CLEAN: begin
        if ($urandom_range(2) == 0) add_blanks();
      end
      FL_OPEN_SQ: begin
        if ($urandom_range(1)) add_blanks();
        line_q.push_back(CH_SQ);
        repeat (n) line_q.push_back(any_but(CH_SQ, CH_SQ));
      end
      FL_OPEN_DQ: begin
        line_q.push_back(CH_DQ);
        repeat (n) line_q.push_back(any_but(CH_DQ, CH_BSL));
        if ($urandom_range(1)) line_q.push_back(CH_BSL);
      end
      FL_TAIL_BSL: begin
        if ($urandom_range(1)) add_blanks();
        line_q.push_back(CH_BSL);
      end
      default: begin
        line_q.delete();
        repeat (n * 3 + 1) line_q.push_back(chr_t'($urandom_range(255, 1)));
      end
    endcase
    line_q.push_back(CH_NUL);
  endfunction

  function automatic flavour_t pick_flavour();
    int sel;
    sel = $urandom_range(99);
    if (sel < 70) return FL_CLEAN;
    if (sel < 77) return FL_OPEN_SQ;
    if (sel < 84) return FL_OPEN_DQ;
    if (sel < 90) return FL_TAIL_BSL;
    return FL_NOISE;
  endfunction

  // Stimulus: reset, directed lines, then random lines over three idling phases.
  initial begin : stimulus
    int   line_no;
    int   rnd_start;
    int   phase;
    int   n_args;
    int   hold_start;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_ch       = '0;
    tx_idle_pct = 28;
    bytes_sent  = 0;
    lines_sent  = 0;
    line_no     = 0;
    phase       = 1;
    hold_start  = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) begin
      send_byte(DIRECTED[i]);
      if (DIRECTED[i] == CH_NUL) lines_sent++;
    end

    // The last phase always runs, and keeps offering bytes during the hold-off.
    rnd_start = bytes_sent;
    while (bytes_sent - rnd_start < RANDOM_BYTES || phase != 3 ||
           bytes_sent - hold_start < HOLD_BYTES) begin
      // Swap the idling rates after a third, then stop idling and hold the
      // receiver off for a long stretch so the block fills up.
      if (phase == 1 && bytes_sent - rnd_start >= RANDOM_BYTES / 3) begin
        phase       = 2;
        tx_idle_pct = 45;
        rx_idle_pct <= 28;
      end else if (phase == 2 && bytes_sent - rnd_start >= 2 * RANDOM_BYTES / 3) begin
        phase       = 3;
        hold_start  = bytes_sent;
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        hold_req    <= 1'b1;
      end
      if (line_no == 1) begin
        // The most arguments a line may hold, the word total with every bit set.
        build_line(ARG_SLOTS - 1, FL_CLEAN, 1'b1);
      end else if (line_no == 3) begin
        // One to three arguments too many: error, then the rest is dropped.
        build_line($urandom_range(ARG_SLOTS + 2, ARG_SLOTS), FL_CLEAN, 1'b1);
      end else begin
        n_args = ($urandom_range(9) == 0) ? $urandom_range(12, 6) : $urandom_range(5, 0);
        build_line(n_args, pick_flavour(), 1'b0);
      end
      foreach (line_q[i]) send_byte(line_q[i]);
      lines_sent++;
      line_no++;
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Fed %0d bytes in %0d lines and checked %0d results:",
             bytes_sent, lines_sent, results_seen);
    $display("%0d lines ended, %0d with errors.", lines_ok, lines_err);
    $display("Idling swapped between sides, then a %0d-cycle receiver hold-off; %0d mismatches.",
             RX_HOLD_CYCLES, fail_count);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
